>>> design/fdrx_pkg.sv
// ----------------------------------------------------------------------------
// fdrx_pkg: shared types and constants of the frame deframer receiver
// Holds the status codes and the result beat layout used by the receiver
// and its port checker.
// ----------------------------------------------------------------------------
package fdrx_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 16;
    localparam int unsigned StatW  = 2;

    // Status codes carried on the result channel.
    localparam logic [StatW-1:0] ST_BUSY = 2'd0;
    localparam logic [StatW-1:0] ST_OK   = 2'd1;
    localparam logic [StatW-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic              data_valid;
        logic [ByteW-1:0]  data_byte;
        logic [CountW-1:0] data_index;
        logic [ByteW-1:0]  frame_tag;
        logic [CountW-1:0] frame_size;
        logic [StatW-1:0]  status;
    } result_t;

endpackage

>>> design/frame_deframer_rx.sv
// ----------------------------------------------------------------------------
// frame_deframer_rx: receive parser for length-prefixed checksummed frames
// Takes one received byte per beat and returns one result beat per byte.
// ----------------------------------------------------------------------------
// A frame on the input is an ID byte, a 16-bit payload length sent low byte
// first, that many payload bytes, and one checksum byte that must equal the
// 8-bit wrapping sum of the payload. Every input beat produces exactly one
// result beat. Payload bytes come out with m_data_valid high and their index
// within the frame; every beat also carries the current frame ID and length.
// The checksum beat reports ST_OK or ST_BAD, after which the parser waits for
// the next ID byte. A zero length skips directly to the checksum byte. The
// block sustains one byte per clock cycle while s_ready is high: the
// parse is a single pass of short logic from the parser state registers into
// the result register, and a one-beat skid register behind the result
// register keeps s_ready a plain register output, so input is still taken
// while a finished result waits for m_ready. s_ready drops only when both the
// result register and the skid register are occupied.
module frame_deframer_rx (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Received byte channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fdrx_pkg::ByteW-1:0]    s_rx_byte,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_data_valid,
    output logic [fdrx_pkg::ByteW-1:0]    m_data_byte,
    output logic [fdrx_pkg::CountW-1:0]   m_data_index,
    output logic [fdrx_pkg::ByteW-1:0]    m_frame_tag,
    output logic [fdrx_pkg::CountW-1:0]   m_frame_size,
    output logic [fdrx_pkg::StatW-1:0]    m_status
);
    import fdrx_pkg::*;

    // Parser phases. Codes 5 to 7 are never reached and fall back to waiting
    // for an ID byte.
    typedef enum logic [2:0] {
        PH_ID     = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHECK  = 3'd4
    } phase_t;

    phase_t            phase_reg,  phase_next;
    logic [ByteW-1:0]  tag_reg,    tag_next;
    logic [CountW-1:0] length_reg, length_next;
    logic [CountW-1:0] count_reg,  count_next;
    logic [ByteW-1:0]  sum_reg,    sum_next;

    result_t           res_next;
    result_t           out_reg;
    result_t           skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    logic              in_beat;
    logic              out_free;
    logic [CountW-1:0] count_inc;

    assign s_ready   = !skid_valid_reg;
    assign in_beat   = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;
    assign count_inc = count_reg + CountW'(1);

    // Single-pass parse of the incoming byte against the current phase.
    always_comb begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;

        res_next            = '0;
        res_next.status     = ST_BUSY;

        unique case (phase_reg)
            PH_LEN_LO: begin
                length_next = {{(CountW-ByteW){1'b0}}, s_rx_byte};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_next = {s_rx_byte, length_reg[ByteW-1:0]};
                count_next  = '0;
                // The zero test looks at the full length, high byte included.
                phase_next  = (length_next == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                res_next.data_valid = 1'b1;
                res_next.data_byte  = s_rx_byte;
                res_next.data_index = count_reg;
                sum_next            = sum_reg + s_rx_byte;
                count_next          = count_inc;
                if (count_inc == length_reg) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                res_next.status = (s_rx_byte == sum_reg) ? ST_OK : ST_BAD;
                phase_next      = PH_ID;
            end
            default: begin
                tag_next    = s_rx_byte;
                length_next = '0;
                count_next  = '0;
                sum_next    = '0;
                phase_next  = PH_LEN_LO;
            end
        endcase

        res_next.frame_tag  = tag_next;
        res_next.frame_size = length_next;
    end

    // Parser state, result register and skid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_ID;
            tag_reg        <= '0;
            length_reg     <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (in_beat) begin
                phase_reg  <= phase_next;
                tag_reg    <= tag_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                sum_reg    <= sum_next;
            end

            if (out_free) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else if (in_beat) begin
                    out_reg       <= res_next;
                    out_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (in_beat) begin
                skid_reg       <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_data_valid = out_reg.data_valid;
    assign m_data_byte  = out_reg.data_byte;
    assign m_data_index = out_reg.data_index;
    assign m_frame_tag  = out_reg.frame_tag;
    assign m_frame_size = out_reg.frame_size;
    assign m_status     = out_reg.status;

endmodule

>>> design/fdrx_checker.sv
// ----------------------------------------------------------------------------
// fdrx_checker: port-level checks for the frame deframer receiver
// Watches the top-level ports and flags illegal result beats.
// ----------------------------------------------------------------------------
module fdrx_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_data_valid,
    input  logic [fdrx_pkg::ByteW-1:0]    m_data_byte,
    input  logic [fdrx_pkg::CountW-1:0]   m_data_index,
    input  logic [fdrx_pkg::ByteW-1:0]    m_frame_tag,
    input  logic [fdrx_pkg::CountW-1:0]   m_frame_size,
    input  logic [fdrx_pkg::StatW-1:0]    m_status
);
    import fdrx_pkg::*;

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_valid)
            && $stable(m_data_byte) && $stable(m_data_index)
            && $stable(m_frame_tag) && $stable(m_frame_size)
            && $stable(m_status))
        else $error("fdrx: stalled result beat changed");

    // A payload beat never closes a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data_valid |-> m_status == ST_BUSY)
        else $error("fdrx: payload beat carries a final status");

    // Non-payload beats carry zero data and index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data_valid |-> m_data_byte == '0 && m_data_index == '0)
        else $error("fdrx: stray data on a non-payload beat");

    // Payload index always lies below the frame length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data_valid |-> m_data_index < m_frame_size)
        else $error("fdrx: payload index beyond frame length");

    // Reset empties the result channel.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("fdrx: result beat valid after reset");

endmodule

bind frame_deframer_rx fdrx_checker u_fdrx_checker (.*);

>>> sim/tb_frame_deframer_rx.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_deframer_rx: self-checking bench for the frame deframer receiver
// Feeds byte beats that form length-prefixed frames, directed corner frames
// first and then random frames with good and corrupted checksums, and checks
// every result beat against a cycle-free parser model kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_frame_deframer_rx;

    import fdrx_pkg::*;

    // Parser phases of the bench's own frame model.
    typedef enum logic [2:0] {
        PH_WAIT_ID  = 3'd0,
        PH_LEN_LO   = 3'd1,
        PH_LEN_HI   = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_CHECKSUM = 3'd4
    } parse_phase_e;

    // Scoreboard: tracks the frame parse for every accepted byte beat and
    // holds the result beats that the block still owes us, oldest first.
    class frame_result_board;
        parse_phase_e      phase;
        logic [ByteW-1:0]  tag;
        logic [CountW-1:0] size;
        logic [CountW-1:0] count;
        logic [ByteW-1:0]  sum;
        result_t           owed_results[$];
        int                errors;

        function new();
            phase  = PH_WAIT_ID;
            tag    = '0;
            size   = '0;
            count  = '0;
            sum    = '0;
            errors = 0;
        endfunction

        // Advance the frame parse by one received byte and queue the result.
        function void note_byte(logic [ByteW-1:0] b);
            result_t r;
            r = '0;
            r.status = ST_BUSY;
            case (phase)
                PH_LEN_LO: begin
                    size  = {8'h00, b};
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    size  = {b, size[7:0]};
                    count = '0;
                    phase = (size == 0) ? PH_CHECKSUM : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    r.data_valid = 1'b1;
                    r.data_byte  = b;
                    r.data_index = count;
                    sum   = sum + b;
                    count = count + 1'b1;
                    if (count == size)
                        phase = PH_CHECKSUM;
                end
                PH_CHECKSUM: begin
                    r.status = (b == sum) ? ST_OK : ST_BAD;
                    phase    = PH_WAIT_ID;
                end
                default: begin
                    tag   = b;
                    size  = '0;
                    count = '0;
                    sum   = '0;
                    phase = PH_LEN_LO;
                end
            endcase
            r.frame_tag  = tag;
            r.frame_size = size;
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result beat with the oldest owed result.
        function void check_beat(result_t got);
            result_t want;
            if (owed_results.size() == 0) begin
                $display("%0t: result beat with none expected, got %0h", $time, got);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("data_valid", 16'(want.data_valid), 16'(got.data_valid));
            compare_field("data_byte",  16'(want.data_byte),  16'(got.data_byte));
            compare_field("data_index", want.data_index, got.data_index);
            compare_field("frame_tag",  16'(want.frame_tag),  16'(got.frame_tag));
            compare_field("frame_size", want.frame_size, got.frame_size);
            compare_field("status",     16'(want.status),     16'(got.status));
        endfunction
    endclass

    localparam int NUM_DIRECTED = 26;
    localparam int RANDOM_BEATS = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 10000;

    // Directed frames, one per line: zero length with a good checksum, zero
    // length with a bad one, a single all-ones payload byte, a payload whose
    // sum wraps past 8 bits, and a short frame with a wrong checksum.
    localparam logic [7:0] DIRECTED_BYTES [NUM_DIRECTED] = '{
        8'hFF, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5A,
        8'hA5, 8'h01, 8'h00, 8'hFF, 8'hFF,
        8'h3C, 8'h03, 8'h00, 8'h80, 8'h81, 8'h01, 8'h02,
        8'h7E, 8'h02, 8'h00, 8'h55, 8'hAA, 8'hFE
    };

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [ByteW-1:0]    s_rx_byte;
    logic                m_valid;
    logic                m_ready;
    logic                m_data_valid;
    logic [ByteW-1:0]    m_data_byte;
    logic [CountW-1:0]   m_data_index;
    logic [ByteW-1:0]    m_frame_tag;
    logic [CountW-1:0]   m_frame_size;
    logic [StatW-1:0]    m_status;

    frame_result_board board = new();

    int sent_beats   = 0;
    bit quiet        = 1'b0;   // both sides stop idling while set
    bit hold_request = 1'b0;   // asks the receiver for one long hold-off

    frame_deframer_rx dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_valid (m_data_valid),
        .m_data_byte  (m_data_byte),
        .m_data_index (m_data_index),
        .m_frame_tag  (m_frame_tag),
        .m_frame_size (m_frame_size),
        .m_status     (m_status)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Offer one byte beat and return at the edge where it is taken. Valid
    // is dropped only for a random idle gap; back-to-back beats keep it high
    // and just change the payload, so valid sees one assignment per step.
    task automatic send_byte(input logic [ByteW-1:0] b);
        while (!quiet && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        // Values read right after the edge are the ones the flops saw.
        do @(posedge aclk); while (!s_ready);
        board.note_byte(b);
        sent_beats++;
    endtask

    // One whole frame with random payload; a corrupted frame gets a checksum
    // that differs from the payload sum by a nonzero pattern.
    task automatic send_frame(input logic [ByteW-1:0] tag, input logic [CountW-1:0] len,
                              input bit corrupt);
        logic [ByteW-1:0] sum;
        logic [ByteW-1:0] b;
        sum = '0;
        send_byte(tag);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b);
        end
        send_byte(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    endtask

    // Result side: check every accepted beat and drive m_ready for the next
    // cycle. A hold-off request keeps m_ready low for a long stretch so the
    // result register and skid register fill up and s_ready has to drop.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                board.check_beat({m_data_valid, m_data_byte, m_data_index,
                                  m_frame_tag, m_frame_size, m_status});
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Main sequence: reset, directed frames, random frames, then drain and
    // report.
    initial begin
        int               kind;
        int               waited;
        logic [CountW-1:0] len;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i]);

        // Stall the result side while the sender keeps pushing frames.
        hold_request = 1'b1;

        // Mostly short well-formed frames, some empty ones, a few whose length
        // uses the upper byte, and about a quarter with a broken checksum.
        while (sent_beats < NUM_DIRECTED + RANDOM_BEATS) begin
            quiet = (sent_beats >= 900 && sent_beats < 1300);
            kind  = $urandom_range(0, 99);
            if (kind < 5)
                len = 16'h0100 + 16'($urandom_range(0, 15));
            else if (kind < 15)
                len = '0;
            else
                len = 16'($urandom_range(1, 16));
            send_frame(8'($urandom_range(0, 255)), len, $urandom_range(0, 99) < 25);
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        waited = 0;
        while (board.owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        // A few more cycles to catch any stray beat after the last one.
        repeat (4) @(posedge aclk);

        if (board.owed_results.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time,
                     board.owed_results.size());
            board.errors++;
        end

        if (board.errors == 0) begin
            $display("frame_deframer_rx: match");
        end else begin
            $display("frame_deframer_rx: mismatch");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("frame_deframer_rx: mismatch");
        $finish;
    end

endmodule

>>> files.f
design/fdrx_pkg.sv
design/frame_deframer_rx.sv
design/fdrx_checker.sv
sim/tb_frame_deframer_rx.sv
